FILE: hdl/ttb_pkg.sv
package ttb_pkg;

    localparam int POS_WIDTH_DEF     = 32;
    localparam int UV_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    // Magnitudes are reduced to this many bits before the length is taken.
    localparam int MAG_BITS  = 30;
    localparam int SQ_BITS   = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS = MAG_BITS + 1;
    localparam int CNT_BITS  = 5;

    localparam int MUL_LAST  = 14;
    localparam int SQ_LAST   = 4;
    localparam int SQRT_LAST = ROOT_BITS - 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOLD,
        OP_EDGES,
        OP_MUL,
        OP_LOAD,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT,
        OP_DINIT,
        OP_DIV,
        OP_DEGEN
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CNT_BITS-1:0] cnt;
        logic                vsel;
        logic [1:0]          comp;
        logic [1:0]          phase;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic vec_zero;
        logic vec_big;
    } status_t;

endpackage

FILE: hdl/triangle_tangent_bitangent.sv
// Tangent and bitangent per triangle from vertex positions and UV coordinates.
// Input: one beat per vertex on s_*, three beats per triangle. tdata carries
// pos_x, pos_y, pos_z (signed Q16.16) and tex_u, tex_v (unsigned Q1.15).
// The first two vertices of a triangle are taken and held.
// Output: one beat on m_* per triangle, after its third vertex. tdata carries
// the unit tangent and bitangent in signed Q1.14; tuser is the degenerate flag,
// set with all-zero vectors when the UV determinant or a vector is zero.
// From the third vertex the steps are: the products on the shared edge
// multiplier, then per vector a load, a range check with single-bit scaling
// shifts as needed, the squares, the bit-serial square root and, per
// component, the restoring divider. A degenerate triangle ends early, right
// after the products when the UV determinant is zero.
// One triangle is in work at a time: s_tready
// is low from the third vertex until the result beat is taken.
// While m_tready is low the result holds on m_tdata and no vertex is taken.
// Reset returns the block to the first vertex of a triangle, no result pending.
module triangle_tangent_bitangent #(
    parameter int POS_WIDTH     = ttb_pkg::POS_WIDTH_DEF,
    parameter int UV_WIDTH      = ttb_pkg::UV_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = ttb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up, zero padded
    input  logic [((3*POS_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic m_tuser
);
    import ttb_pkg::*;

    localparam int OW     = OUT_FRAC_BITS + 2;
    localparam int OUT_TW = ((6 * OW + 7) / 8) * 8;

    cmd_t    cmd;
    status_t status;
    logic [OW-1:0] tx, ty, tz, bx, by, bz;

    ttb_controller #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ttb_datapath #(
        .POS_WIDTH    (POS_WIDTH),
        .UV_WIDTH     (UV_WIDTH),
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .status     (status),
        .pos_x      (s_tdata[POS_WIDTH-1:0]),
        .pos_y      (s_tdata[2*POS_WIDTH-1:POS_WIDTH]),
        .pos_z      (s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
        .tex_u      (s_tdata[3*POS_WIDTH+UV_WIDTH-1:3*POS_WIDTH]),
        .tex_v      (s_tdata[3*POS_WIDTH+2*UV_WIDTH-1:3*POS_WIDTH+UV_WIDTH]),
        .tangent_x  (tx),
        .tangent_y  (ty),
        .tangent_z  (tz),
        .bitangent_x(bx),
        .bitangent_y(by),
        .bitangent_z(bz),
        .degenerate (m_tuser)
    );

    assign m_tdata = OUT_TW'({bz, by, bx, tz, ty, tx});

endmodule

FILE: hdl/ttb_controller.sv
module ttb_controller #(
    parameter int OUT_FRAC_BITS = ttb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ttb_pkg::status_t status,
    output ttb_pkg::cmd_t    cmd
);
    import ttb_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]          comp_reg, comp_next;
    logic                vsel_reg, vsel_next;
    logic [1:0]          phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            vsel_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            vsel_reg  <= vsel_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        vsel_next  = vsel_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (phase_reg == 2'd2) begin
                        phase_next = 2'd0;
                        state_next = ST_MUL;
                        cnt_next   = '0;
                    end else begin
                        phase_next = (phase_reg == 2'd1) ? 2'd2 : 2'd1;
                    end
                end
            end
            ST_MUL: begin
                if (cnt_reg == CNT_BITS'(MUL_LAST)) begin
                    state_next = ST_LOAD;
                    vsel_next  = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LOAD: begin
                if (!vsel_reg && status.det_zero) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (status.vec_zero) begin
                    state_next = ST_OUT;
                end else if (!status.vec_big) begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ: begin
                if (cnt_reg == CNT_BITS'(SQ_LAST)) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == CNT_BITS'(SQRT_LAST)) begin
                    state_next = ST_DINIT;
                    comp_next  = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_BITS'(OUT_FRAC_BITS)) begin
                    if (comp_reg == 2'd2) begin
                        if (vsel_reg) begin
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_LOAD;
                            vsel_next  = 1'b1;
                        end
                    end else begin
                        state_next = ST_DINIT;
                        comp_next  = comp_reg + 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        cmd.op    = OP_NONE;
        cmd.cnt   = cnt_reg;
        cmd.vsel  = vsel_reg;
        cmd.comp  = comp_reg;
        cmd.phase = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = (phase_reg == 2'd2) ? OP_EDGES : OP_HOLD;
                end
            end
            ST_MUL:   cmd.op = OP_MUL;
            ST_LOAD:  cmd.op = (!vsel_reg && status.det_zero) ? OP_DEGEN : OP_LOAD;
            ST_SHIFT: begin
                if (status.vec_zero) begin
                    cmd.op = OP_DEGEN;
                end else if (status.vec_big) begin
                    cmd.op = OP_SHIFT;
                end
            end
            ST_SQ:    cmd.op = OP_SQ;
            ST_SQRT:  cmd.op = OP_SQRT;
            ST_DINIT: cmd.op = OP_DINIT;
            ST_DIV:   cmd.op = OP_DIV;
            ST_OUT:   m_tvalid = 1'b1;
            default:  cmd.op = OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output handshakes open together");
    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after a result beat");
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("vertex phase left its range");
    a_third_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && phase_reg == 2'd2) |=>
            (state_reg == ST_MUL && cnt_reg == '0 && phase_reg == 2'd0))
        else $error("third vertex did not start the product sequence");
`endif

endmodule

FILE: hdl/ttb_datapath.sv
module ttb_datapath #(
    parameter int POS_WIDTH     = ttb_pkg::POS_WIDTH_DEF,
    parameter int UV_WIDTH      = ttb_pkg::UV_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = ttb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  ttb_pkg::cmd_t               cmd,
    output ttb_pkg::status_t            status,
    input  logic [POS_WIDTH-1:0]        pos_x,
    input  logic [POS_WIDTH-1:0]        pos_y,
    input  logic [POS_WIDTH-1:0]        pos_z,
    input  logic [UV_WIDTH-1:0]         tex_u,
    input  logic [UV_WIDTH-1:0]         tex_v,
    output logic [OUT_FRAC_BITS+1:0]    tangent_x,
    output logic [OUT_FRAC_BITS+1:0]    tangent_y,
    output logic [OUT_FRAC_BITS+1:0]    tangent_z,
    output logic [OUT_FRAC_BITS+1:0]    bitangent_x,
    output logic [OUT_FRAC_BITS+1:0]    bitangent_y,
    output logic [OUT_FRAC_BITS+1:0]    bitangent_z,
    output logic                        degenerate
);
    import ttb_pkg::*;

    localparam int EW   = POS_WIDTH + 1;
    localparam int DW   = UV_WIDTH + 1;
    localparam int AW   = (EW > DW) ? EW : DW;
    localparam int PW   = AW + DW;
    localparam int VW   = PW + 1;
    localparam int DETW = 2 * UV_WIDTH + 3;
    localparam int MW   = (VW > MAG_BITS) ? VW : MAG_BITS + 1;
    localparam int RMW  = MAG_BITS + 4;
    localparam int DVW  = MAG_BITS + OUT_FRAC_BITS + 2;
    localparam int OW   = OUT_FRAC_BITS + 2;
    localparam int QW   = OUT_FRAC_BITS + 1;

    logic [POS_WIDTH-1:0]  pin [3];
    logic [POS_WIDTH-1:0]  p0_reg [3];
    logic [POS_WIDTH-1:0]  p1_reg [3];
    logic [UV_WIDTH-1:0]   t0u_reg, t0v_reg, t1u_reg, t1v_reg;
    logic [EW-1:0]         e1_reg [3];
    logic [EW-1:0]         e2_reg [3];
    logic signed [DW-1:0]  d1u_reg, d1v_reg, d2u_reg, d2v_reg;

    logic signed [AW-1:0]  mul_a;
    logic signed [DW-1:0]  mul_b;
    logic signed [PW-1:0]  prod_reg;
    logic [1:0]            mi, ai;
    logic [CNT_BITS-1:0]   pc;
    logic signed [VW-1:0]  tan_reg [3];
    logic signed [VW-1:0]  bit_reg [3];
    logic signed [DETW-1:0] det_reg;

    logic [MW-1:0]         mag_reg [3];
    logic                  neg_reg [3];
    logic [MW-1:0]         or_all;

    logic [MAG_BITS-1:0]   sq_in;
    logic [2*MAG_BITS-1:0] sqp_reg;
    logic [SQ_BITS-1:0]    sum_reg;
    logic [SQ_BITS-1:0]    sx_reg;
    logic [RMW-1:0]        srem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [RMW-1:0]        rem_sh, trial;

    logic [DVW-1:0]        drem_reg, dsr_reg;
    logic [QW-1:0]         q_reg, qb;
    logic                  ge;
    logic [OW-1:0]         qres;
    logic [OW-1:0]         tres_reg [3];
    logic [OW-1:0]         bres_reg [3];
    logic                  deg_reg;

    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    assign mi = cmd.cnt[3:2];
    assign pc = cmd.cnt - 1'b1;
    assign ai = pc[3:2];

    // Products 0..11 build the vectors, four per component; 12 and 13 form det.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (mi == 2'd3) begin
            if (!cmd.cnt[0]) begin
                mul_a = AW'(d1u_reg);
                mul_b = d2v_reg;
            end else begin
                mul_a = AW'(d1v_reg);
                mul_b = d2u_reg;
            end
        end else begin
            unique case (cmd.cnt[1:0])
                2'd0: begin mul_a = AW'($signed(e1_reg[mi])); mul_b = d2v_reg; end
                2'd1: begin mul_a = AW'($signed(e2_reg[mi])); mul_b = d1v_reg; end
                2'd2: begin mul_a = AW'($signed(e2_reg[mi])); mul_b = d1u_reg; end
                default: begin mul_a = AW'($signed(e1_reg[mi])); mul_b = d2u_reg; end
            endcase
        end
    end

    assign or_all = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign status.det_zero = (det_reg == '0);
    assign status.vec_zero = (or_all == '0);
    assign status.vec_big  = |or_all[MW-1:MAG_BITS];

    assign sq_in = (cmd.cnt[1:0] == 2'd3) ? '0 : mag_reg[cmd.cnt[1:0]][MAG_BITS-1:0];

    assign rem_sh = {srem_reg[RMW-3:0], sx_reg[SQ_BITS-1:SQ_BITS-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    assign ge   = (drem_reg >= dsr_reg);
    assign qb   = {q_reg[QW-2:0], ge};
    assign qres = neg_reg[cmd.comp] ? (OW'(0) - OW'(qb)) : OW'(qb);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_HOLD: begin
                if (cmd.phase == 2'd1) begin
                    for (int i = 0; i < 3; i++) p1_reg[i] <= pin[i];
                    t1u_reg <= tex_u;
                    t1v_reg <= tex_v;
                end else begin
                    for (int i = 0; i < 3; i++) p0_reg[i] <= pin[i];
                    t0u_reg <= tex_u;
                    t0v_reg <= tex_v;
                end
            end
            OP_EDGES: begin
                for (int i = 0; i < 3; i++) begin
                    e1_reg[i] <= {p1_reg[i][POS_WIDTH-1], p1_reg[i]}
                               - {p0_reg[i][POS_WIDTH-1], p0_reg[i]};
                    e2_reg[i] <= {pin[i][POS_WIDTH-1], pin[i]}
                               - {p0_reg[i][POS_WIDTH-1], p0_reg[i]};
                end
                d1u_reg <= $signed({1'b0, t1u_reg} - {1'b0, t0u_reg});
                d1v_reg <= $signed({1'b0, t1v_reg} - {1'b0, t0v_reg});
                d2u_reg <= $signed({1'b0, tex_u} - {1'b0, t0u_reg});
                d2v_reg <= $signed({1'b0, tex_v} - {1'b0, t0v_reg});
                deg_reg <= 1'b0;
            end
            OP_MUL: begin
                prod_reg <= mul_a * mul_b;
                if (cmd.cnt != '0) begin
                    if (ai == 2'd3) begin
                        if (!pc[0]) det_reg <= DETW'(prod_reg);
                        else        det_reg <= det_reg - DETW'(prod_reg);
                    end else begin
                        unique case (pc[1:0])
                            2'd0:    tan_reg[ai] <= VW'(prod_reg);
                            2'd1:    tan_reg[ai] <= tan_reg[ai] - VW'(prod_reg);
                            2'd2:    bit_reg[ai] <= VW'(prod_reg);
                            default: bit_reg[ai] <= bit_reg[ai] - VW'(prod_reg);
                        endcase
                    end
                end
            end
            OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    logic [VW-1:0] v;
                    v = cmd.vsel ? bit_reg[i] : tan_reg[i];
                    neg_reg[i] <= v[VW-1] ^ det_reg[DETW-1];
                    mag_reg[i] <= MW'(v[VW-1] ? (~v + 1'b1) : v);
                end
            end
            OP_SHIFT: begin
                for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
            end
            OP_SQ: begin
                sqp_reg <= sq_in * sq_in;
                if (cmd.cnt == CNT_BITS'(1)) begin
                    sum_reg <= SQ_BITS'(sqp_reg);
                end else if (cmd.cnt == CNT_BITS'(2) || cmd.cnt == CNT_BITS'(3)) begin
                    sum_reg <= sum_reg + SQ_BITS'(sqp_reg);
                end
                if (cmd.cnt == CNT_BITS'(SQ_LAST)) begin
                    sx_reg   <= sum_reg;
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            OP_SQRT: begin
                if (rem_sh >= trial) begin
                    srem_reg <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    srem_reg <= rem_sh;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                sx_reg <= sx_reg << 2;
            end
            OP_DINIT: begin
                drem_reg <= (DVW'(mag_reg[cmd.comp][MAG_BITS-1:0]) << OUT_FRAC_BITS)
                          + DVW'(root_reg >> 1);
                dsr_reg  <= DVW'(root_reg) << OUT_FRAC_BITS;
                q_reg    <= '0;
            end
            OP_DIV: begin
                if (ge) drem_reg <= drem_reg - dsr_reg;
                dsr_reg <= dsr_reg >> 1;
                q_reg   <= qb;
                if (cmd.cnt == CNT_BITS'(OUT_FRAC_BITS)) begin
                    if (cmd.vsel) bres_reg[cmd.comp] <= qres;
                    else          tres_reg[cmd.comp] <= qres;
                end
            end
            OP_DEGEN: begin
                deg_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    tres_reg[i] <= '0;
                    bres_reg[i] <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign tangent_x   = tres_reg[0];
    assign tangent_y   = tres_reg[1];
    assign tangent_z   = tres_reg[2];
    assign bitangent_x = bres_reg[0];
    assign bitangent_y = bres_reg[1];
    assign bitangent_z = bres_reg[2];
    assign degenerate  = deg_reg;

endmodule
